/* sv/tcw_pkg.sv */
// Package for the text console writer: screen geometry, field widths,
// character codes, operation codes, the command passed front to back, and states.
// No dependencies.
package tcw_pkg;

   localparam int COLS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = ROWS * COLS;

   localparam int FUNC_W = 3;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = 11;
   localparam int LINES_W = 5;
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int CELL_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd127;
   localparam logic [COL_W:0] TAB_MASK = ~(COL_W + 1)'(7);
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
   localparam logic [CHAR_W-1:0] FILL_RESET = 8'd7;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUT = 3'd0,
      FN_READ = 3'd1,
      FN_CLEAR = 3'd2,
      FN_SCROLL = 3'd3,
      FN_CURSOR = 3'd4
   } func_type;

   typedef struct packed {
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic [LINES_W-1:0] shift_n;
      logic [COL_W-1:0] cur_col;
      logic [ROW_W-1:0] cur_row;
      logic [ADDR_W-1:0] cur_pos;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_COPY_RD,
      BK_COPY_WR,
      BK_FILL,
      BK_DONE
   } bk_state_type;

endpackage

/* sv/tcw_if.sv */
// Channel interfaces of the text console writer: request, response and
// configuration write, each with valid, ready and its payload. Depends on tcw_pkg.
interface tcw_req_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::FUNC_W-1:0] func;
   logic [tcw_pkg::CHAR_W-1:0] char_code;
   logic [tcw_pkg::CHAR_W-1:0] char_color;
   logic [tcw_pkg::ADDR_W-1:0] cell_index;
   logic [tcw_pkg::LINES_W-1:0] scroll_lines;
   logic [tcw_pkg::COL_W-1:0] new_col;
   logic [tcw_pkg::ROW_W-1:0] new_row;

   modport source (output valid, func, char_code, char_color, cell_index, scroll_lines,
                   new_col, new_row, input ready);
   modport sink (input valid, func, char_code, char_color, cell_index, scroll_lines,
                 new_col, new_row, output ready);
endinterface

interface tcw_rsp_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::CELL_W-1:0] cell_data;
   logic [tcw_pkg::COL_W-1:0] cursor_col;
   logic [tcw_pkg::ROW_W-1:0] cursor_row;
   logic [tcw_pkg::ADDR_W-1:0] cursor_pos;

   modport source (output valid, cell_data, cursor_col, cursor_row, cursor_pos,
                   input ready);
   modport sink (input valid, cell_data, cursor_col, cursor_row, cursor_pos,
                 output ready);
endinterface

interface tcw_csr_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::CHAR_W-1:0] fill_color;

   modport source (output valid, fill_color, input ready);
   modport sink (input valid, fill_color, output ready);
endinterface

/* sv/text_console_writer_top.sv */
// Text console writer: an 80 x 25 text screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor. A request beat carries one operation: put char,
// read cell, clear, scroll up by n lines, or set cursor; each returns one response beat
// with the cell read (zero unless read cell in range) and the cursor after the
// operation. The front end takes a request per cycle, while the queue has room, into a
// two-entry command queue; the back end works the single-port cell store: put char
// without a scroll, read cell, set cursor, scroll by zero and the unused codes make at
// most one store access each; a scroll by n lines with n from 1 to 24 (a newline or
// wrap off the last row gives n = 1) copies the lower 25-n rows up, a read then a write
// per cell, and blanks the last n rows; clear and a scroll by 25 or more blank every
// cell. No request beat is taken during the blanking after reset; fill_color writes are
// taken at any time. Depends on tcw_pkg, tcw_if, tcw_front, tcw_queue and tcw_back.
module text_console_writer_top (
   input logic clock,
   input logic reset,
   tcw_req_if.sink req_chan,
   tcw_rsp_if.source rsp_chan,
   tcw_csr_if.sink csr_chan
);
   import tcw_pkg::*;

   cmd_type push_data;
   cmd_type head;
   logic push;
   logic pop;
   logic full;
   logic empty;
   logic init_busy;

   tcw_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .init_busy(init_busy),
      .q_full(full),
      .q_push(push),
      .q_data(push_data)
   );

   tcw_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .head(head),
      .full(full),
      .empty(empty)
   );

   tcw_back u_back (
      .clock(clock),
      .reset(reset),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan),
      .q_head(head),
      .q_empty(empty),
      .q_pop(pop),
      .init_busy(init_busy)
   );

endmodule

/* sv/tcw_front.sv */
// Front end: accepts request beats, keeps the cursor and turns each request
// into one cell-store command for the back end. Depends on tcw_pkg and tcw_if.
module tcw_front (
   input logic clock,
   input logic reset,
   tcw_req_if.sink req_chan,
   input logic init_busy,
   input logic q_full,
   output logic q_push,
   output tcw_pkg::cmd_type q_data
);
   import tcw_pkg::*;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [COL_W:0] col_nx;
   logic [ROW_W:0] row_nx;
   logic [ADDR_W-1:0] base;
   logic [LINES_W-1:0] lines_c;
   cmd_type cmd;

   assign req_chan.ready = !q_full && !init_busy;
   assign q_push = req_chan.valid && req_chan.ready;
   assign q_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      base = ADDR_W'(row_ff * COLS);
      col_nx = {1'b0, col_ff};
      row_nx = {1'b0, row_ff};
      lines_c = '0;
      cmd = '0;
      case (req_chan.func)
         FN_PUT: begin
            if (req_chan.char_code == CH_LF) begin
               col_nx = '0;
               row_nx = row_nx + 1'b1;
            end else if (req_chan.char_code == CH_CR) begin
               col_nx = '0;
            end else if (req_chan.char_code == CH_TAB) begin
               col_nx = (col_nx + (COL_W + 1)'(8)) & TAB_MASK;
            end else if (req_chan.char_code == CH_BS) begin
               if (col_ff != '0) begin
                  col_nx = col_nx - 1'b1;
                  cmd.wr_en = 1'b1;
                  cmd.wr_addr = base + ADDR_W'(col_ff) - 1'b1;
                  cmd.wr_data = {req_chan.char_color, CH_BLANK};
               end
            end else if (req_chan.char_code inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
               col_nx = col_nx + 1'b1;
               cmd.wr_en = 1'b1;
               cmd.wr_addr = base + ADDR_W'(col_ff);
               cmd.wr_data = {req_chan.char_color, req_chan.char_code};
            end
            if (col_nx >= (COL_W + 1)'(COLS)) begin
               col_nx = '0;
               row_nx = row_nx + 1'b1;
            end
            if (row_nx >= (ROW_W + 1)'(ROWS)) begin
               cmd.shift_n = LINES_W'(1);
               row_nx = (ROW_W + 1)'(ROWS - 1);
            end
         end
         FN_READ: begin
            if (req_chan.cell_index < ADDR_W'(CELLS)) begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = req_chan.cell_index;
            end
         end
         FN_CLEAR: begin
            cmd.shift_n = LINES_W'(ROWS);
            col_nx = '0;
            row_nx = '0;
         end
         FN_SCROLL: begin
            lines_c = (req_chan.scroll_lines > LINES_W'(ROWS)) ? LINES_W'(ROWS)
                                                               : req_chan.scroll_lines;
            cmd.shift_n = lines_c;
            row_nx = (row_ff >= ROW_W'(lines_c)) ? {1'b0, row_ff - ROW_W'(lines_c)} : '0;
         end
         FN_CURSOR: begin
            col_nx = (req_chan.new_col >= COL_W'(COLS)) ? (COL_W + 1)'(COLS - 1)
                                                       : {1'b0, req_chan.new_col};
            row_nx = (req_chan.new_row >= ROW_W'(ROWS)) ? (ROW_W + 1)'(ROWS - 1)
                                                       : {1'b0, req_chan.new_row};
         end
         default: begin
         end
      endcase
      cmd.cur_col = col_nx[COL_W-1:0];
      cmd.cur_row = row_nx[ROW_W-1:0];
      cmd.cur_pos = ADDR_W'(row_nx * COLS) + ADDR_W'(col_nx);
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         col_in = col_nx[COL_W-1:0];
         row_in = row_nx[ROW_W-1:0];
      end
   end

endmodule

/* sv/tcw_queue.sv */
// Short command queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input tcw_pkg::cmd_type push_data,
   input logic pop,
   output tcw_pkg::cmd_type head,
   output logic full,
   output logic empty
);
   import tcw_pkg::*;

   cmd_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/tcw_back.sv */
// Back end: owns the cell store and the fill attribute, carries out cell writes,
// reads, scroll copies and blank fills, and holds the response register.
// Depends on tcw_pkg and tcw_if.
module tcw_back (
   input logic clock,
   input logic reset,
   tcw_rsp_if.source rsp_chan,
   tcw_csr_if.sink csr_chan,
   input tcw_pkg::cmd_type q_head,
   input logic q_empty,
   output logic q_pop,
   output logic init_busy
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   bk_state_type state_ff;
   bk_state_type state_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] idx_in;
   logic [ADDR_W-1:0] src_ff;
   logic [ADDR_W-1:0] src_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic [CHAR_W-1:0] fill_ff;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [CELL_W-1:0] data_ff;
   logic [CELL_W-1:0] data_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;

   logic mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   assign init_busy = (state_ff == BK_INIT);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.cell_data = data_ff;
   assign rsp_chan.cursor_col = col_ff;
   assign rsp_chan.cursor_row = row_ff;
   assign rsp_chan.cursor_pos = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_INIT;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fill_ff <= FILL_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            fill_ff <= csr_chan.fill_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      cmd_ff <= cmd_in;
      data_ff <= data_in;
      col_ff <= col_in;
      row_ff <= row_in;
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      src_in = src_ff;
      cmd_in = cmd_ff;
      q_pop = 1'b0;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {fill_ff, CH_BLANK};
      mem_re = 1'b0;
      mem_raddr = src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      data_in = data_ff;
      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      case (state_ff)
         BK_INIT: begin
            mem_we = 1'b1;
            mem_wdata = RESET_CELL;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == ADDR_W'(CELLS - 1)) begin
               idx_in = '0;
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_head;
               mem_we = q_head.wr_en;
               mem_waddr = q_head.wr_addr;
               mem_wdata = q_head.wr_data;
               mem_re = q_head.rd_en;
               mem_raddr = q_head.rd_addr;
               idx_in = '0;
               src_in = ADDR_W'(q_head.shift_n * COLS);
               if (q_head.shift_n == '0) begin
                  state_in = BK_DONE;
               end else if (q_head.shift_n >= LINES_W'(ROWS)) begin
                  state_in = BK_FILL;
               end else begin
                  state_in = BK_COPY_RD;
               end
            end
         end
         BK_COPY_RD: begin
            mem_re = 1'b1;
            state_in = BK_COPY_WR;
         end
         BK_COPY_WR: begin
            mem_we = 1'b1;
            mem_wdata = rdata_ff;
            idx_in = idx_ff + 1'b1;
            src_in = src_ff + 1'b1;
            state_in = (src_ff == ADDR_W'(CELLS - 1)) ? BK_FILL : BK_COPY_RD;
         end
         BK_FILL: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == ADDR_W'(CELLS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               data_in = cmd_ff.rd_en ? rdata_ff : '0;
               col_in = cmd_ff.cur_col;
               row_in = cmd_ff.cur_row;
               pos_in = cmd_ff.cur_pos;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

endmodule

/* tb/tcw_checker.sv */
// Response checker for the text console writer: predicts each response from the
// request and fill_color beats it watches, and compares it field by field.
// Depends on tcw_pkg and the channel interfaces in tcw_if.
module tcw_checker (
   input logic clock,
   input logic reset,
   tcw_req_if req_mon,
   tcw_rsp_if rsp_mon,
   tcw_csr_if csr_mon,
   output int error_count,
   output int pending_count,
   output int checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [ADDR_W-1:0] pos;
   } cursor_report_type;

   logic [CELL_W-1:0] screen [CELLS];
   int unsigned col_now;
   int unsigned row_now;
   logic [CHAR_W-1:0] fill_now;
   cursor_report_type expected_reports[$];
   cursor_report_type want_report;
   cursor_report_type got_report;
   int errors;
   int checked;
   bit beat_bad;

   function automatic logic [CELL_W-1:0] blank_cell(logic [CHAR_W-1:0] attr);
      return {attr, CH_BLANK};
   endfunction

   function automatic void shift_screen_up(int unsigned n);
      int unsigned keep;
      if (n == 0)
         return;
      if (n > ROWS)
         n = ROWS;
      keep = (ROWS - n) * COLS;
      for (int unsigned i = 0; i < keep; i++)
         screen[i] = screen[i + n * COLS];
      for (int unsigned i = keep; i < CELLS; i++)
         screen[i] = blank_cell(fill_now);
   endfunction

   function automatic void put_char(logic [CHAR_W-1:0] code, logic [CHAR_W-1:0] attr);
      if (code == CH_LF) begin
         col_now = 0;
         row_now++;
      end else if (code == CH_CR) begin
         col_now = 0;
      end else if (code == CH_TAB) begin
         col_now = (col_now + 8) / 8 * 8;
      end else if (code == CH_BS) begin
         if (col_now > 0) begin
            col_now--;
            screen[row_now * COLS + col_now] = blank_cell(attr);
         end
      end else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
         screen[row_now * COLS + col_now] = {attr, code};
         col_now++;
      end
      if (col_now >= COLS) begin
         col_now = 0;
         row_now++;
      end
      if (row_now >= ROWS) begin
         shift_screen_up(row_now - ROWS + 1);
         row_now = ROWS - 1;
      end
   endfunction

   function automatic cursor_report_type predict_report(
      logic [FUNC_W-1:0] func,
      logic [CHAR_W-1:0] code,
      logic [CHAR_W-1:0] color,
      logic [ADDR_W-1:0] cidx,
      logic [LINES_W-1:0] nlines,
      logic [COL_W-1:0] ncol,
      logic [ROW_W-1:0] nrow
   );
      cursor_report_type r;
      int unsigned n;
      r.cell_data = '0;
      case (func)
         FN_PUT: begin
            put_char(code, color);
         end
         FN_READ: begin
            if (int'(cidx) < CELLS)
               r.cell_data = screen[cidx];
         end
         FN_CLEAR: begin
            for (int unsigned i = 0; i < CELLS; i++)
               screen[i] = blank_cell(fill_now);
            col_now = 0;
            row_now = 0;
         end
         FN_SCROLL: begin
            n = (int'(nlines) > ROWS) ? ROWS : int'(nlines);
            shift_screen_up(n);
            row_now = (row_now >= n) ? row_now - n : 0;
         end
         FN_CURSOR: begin
            col_now = (int'(ncol) < COLS) ? int'(ncol) : COLS - 1;
            row_now = (int'(nrow) < ROWS) ? int'(nrow) : ROWS - 1;
         end
         default: begin
         end
      endcase
      r.col = COL_W'(col_now);
      r.row = ROW_W'(row_now);
      r.pos = ADDR_W'(row_now * COLS + col_now);
      return r;
   endfunction

   function automatic bit field_matches(string field, int unsigned want, int unsigned got);
      if (want == got)
         return 1'b1;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int unsigned i = 0; i < CELLS; i++)
            screen[i] = RESET_CELL;
         col_now = 0;
         row_now = 0;
         fill_now = FILL_RESET;
         expected_reports.delete();
         errors = 0;
         checked = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            fill_now = csr_mon.fill_color;
         // retire the response first: it always belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_report.cell_data = rsp_mon.cell_data;
            got_report.col = rsp_mon.cursor_col;
            got_report.row = rsp_mon.cursor_row;
            got_report.pos = rsp_mon.cursor_pos;
            checked++;
            if (expected_reports.size() == 0) begin
               errors++;
               $display("%0t: response beat with none expected, expected nothing, actual 0x%0h",
                        $time, got_report);
            end else begin
               want_report = expected_reports.pop_front();
               beat_bad = 1'b0;
               beat_bad |= !field_matches("cell_data", 32'(want_report.cell_data),
                                          32'(got_report.cell_data));
               beat_bad |= !field_matches("cursor_col", 32'(want_report.col),
                                          32'(got_report.col));
               beat_bad |= !field_matches("cursor_row", 32'(want_report.row),
                                          32'(got_report.row));
               beat_bad |= !field_matches("cursor_pos", 32'(want_report.pos),
                                          32'(got_report.pos));
               if (beat_bad)
                  errors++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_reports.push_back(predict_report(req_mon.func, req_mon.char_code,
                                                      req_mon.char_color, req_mon.cell_index,
                                                      req_mon.scroll_lines, req_mon.new_col,
                                                      req_mon.new_row));
      end
      error_count <= errors;
      pending_count <= expected_reports.size();
      checked_count <= checked;
   end

endmodule

/* tb/testbench.sv */
// Top of the text console writer testbench: clock, reset, request and fill_color
// stimulus with random idling, response back-pressure, watchdog and verdict.
// Depends on tcw_pkg, tcw_if, text_console_writer_top and tcw_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 245;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [CHAR_W-1:0] char_color;
      logic [ADDR_W-1:0] cell_index;
      logic [LINES_W-1:0] scroll_lines;
      logic [COL_W-1:0] new_col;
      logic [ROW_W-1:0] new_row;
   } request_type;

   logic clock;
   logic reset;
   bit quiet;
   int error_count;
   int pending_count;
   int checked_count;
   int stall_cycles;
   int func_count[8];
   int fill_settings;

   tcw_req_if req_chan();
   tcw_rsp_if rsp_chan();
   tcw_csr_if csr_chan();

   text_console_writer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   tcw_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_mon(csr_chan),
      .error_count(error_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic request_type make_request(
      logic [FUNC_W-1:0] func,
      logic [CHAR_W-1:0] code = '0,
      logic [CHAR_W-1:0] color = '0,
      logic [ADDR_W-1:0] cidx = '0,
      logic [LINES_W-1:0] nlines = '0,
      logic [COL_W-1:0] ncol = '0,
      logic [ROW_W-1:0] nrow = '0
   );
      request_type r;
      r.func = func;
      r.char_code = code;
      r.char_color = color;
      r.cell_index = cidx;
      r.scroll_lines = nlines;
      r.new_col = ncol;
      r.new_row = nrow;
      return r;
   endfunction

   // mostly text with colors and control bytes; some reads, cursor moves,
   // screen passes and ignored items
   function automatic request_type random_request(output bit ignored);
      request_type r;
      int unsigned pick;
      r.func = FN_PUT;
      r.char_code = CHAR_W'($urandom);
      r.char_color = CHAR_W'($urandom);
      r.cell_index = ADDR_W'($urandom);
      r.scroll_lines = LINES_W'($urandom);
      r.new_col = COL_W'($urandom);
      r.new_row = ROW_W'($urandom);
      ignored = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.char_code = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      end else if (pick < 61) begin
         case ($urandom_range(0, 3))
            0: r.char_code = CH_LF;
            1: r.char_code = CH_CR;
            2: r.char_code = CH_TAB;
            default: r.char_code = CH_BS;
         endcase
      end else if (pick < 64) begin
         if ((r.char_code >= CH_PRINT_LO && r.char_code <= CH_PRINT_HI) ||
             r.char_code == CH_LF || r.char_code == CH_CR ||
             r.char_code == CH_TAB || r.char_code == CH_BS)
            r.char_code[CHAR_W-1] = 1'b1;
         ignored = 1'b1;
      end else if (pick < 80) begin
         r.func = FN_READ;
         if ($urandom_range(0, 7) != 0)
            r.cell_index = ADDR_W'($urandom_range(0, CELLS - 1));
      end else if (pick < 90) begin
         r.func = FN_CURSOR;
         if ($urandom_range(0, 3) == 0)
            r.new_col = COL_W'($urandom_range(COLS - 8, COLS - 1));
      end else if (pick < 92) begin
         r.func = FN_CLEAR;
      end else if (pick < 95) begin
         r.func = FN_SCROLL;
      end else begin
         r.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
         ignored = 1'b1;
      end
      return r;
   endfunction

   task automatic send_request(input request_type r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= r.func;
      req_chan.char_code <= r.char_code;
      req_chan.char_color <= r.char_color;
      req_chan.cell_index <= r.cell_index;
      req_chan.scroll_lines <= r.scroll_lines;
      req_chan.new_col <= r.new_col;
      req_chan.new_row <= r.new_row;
      do @(posedge clock); while (!req_chan.ready);
      func_count[r.func]++;
   endtask

   // drop valid and hold until every outstanding response beat is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fill(input logic [CHAR_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.fill_color <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      fill_settings++;
   endtask

   // response back-pressure in random bursts, none in the quiet phase
   initial begin
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d responses outstanding",
                     $time, stall_cycles, pending_count);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      request_type r;
      bit ignored;
      int counted;
      logic [CHAR_W-1:0] fill;
      quiet = 1'b0;
      fill_settings = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.func <= FN_PUT;
      req_chan.char_code <= '0;
      req_chan.char_color <= '0;
      req_chan.cell_index <= '0;
      req_chan.scroll_lines <= '0;
      req_chan.new_col <= '0;
      req_chan.new_row <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.fill_color <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset fill color
      send_request(make_request(FN_READ, 0, 0, ADDR_W'(CELLS - 1)));
      send_request(make_request(FN_READ, 0, 0, '1));
      send_request(make_request(FN_PUT, 8'h41, 8'h1E));
      send_request(make_request(FN_PUT, CH_PRINT_LO, 8'h00));
      send_request(make_request(FN_PUT, CH_PRINT_HI, 8'hFF));
      send_request(make_request(FN_PUT, CH_PRINT_LO - 8'd1, 8'hA5));
      send_request(make_request(FN_PUT, CH_PRINT_HI + 8'd1, 8'h5A));
      send_request(make_request(FN_PUT, 8'hFF, 8'hFF));
      send_request(make_request(FN_PUT, CH_TAB, 8'h00));
      send_request(make_request(FN_PUT, CH_BS, 8'h4C));
      send_request(make_request(FN_READ, 0, 0, 7));
      send_request(make_request(FN_PUT, CH_CR, 8'h00));
      send_request(make_request(FN_PUT, CH_BS, 8'h33));
      send_request(make_request(FN_PUT, CH_LF, 8'h00));
      send_request(make_request(FN_CURSOR, 0, 0, 0, 0, '1, '1));
      send_request(make_request(FN_PUT, 8'h5A, 8'hC3));
      send_request(make_request(FN_READ, 0, 0, ADDR_W'((ROWS - 1) * COLS - 1)));
      send_request(make_request(FN_CURSOR, 0, 0, 0, 0, COL_W'(COLS - 5), ROW_W'(ROWS - 1)));
      send_request(make_request(FN_PUT, CH_TAB, 8'h00));
      send_request(make_request(FN_SCROLL, 0, 0, 0, 0));
      send_request(make_request(FN_SCROLL, 0, 0, 0, 1));
      send_request(make_request(FN_SCROLL, 0, 0, 0, '1));
      send_request(make_request(FN_CLEAR));
      send_request(make_request(FN_UNUSED_LO, '1, '1, '1, '1, '1, '1));
      send_request(make_request(FN_UNUSED_HI));
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: fill = 8'hFF;
            1: fill = 8'h00;
            default: fill = CHAR_W'($urandom);
         endcase
         write_fill(fill);
         quiet = (p == PHASES - 1);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = random_request(ignored);
            send_request(r);
            if (!ignored)
               counted++;
         end
         wait_drained();
      end

      $display("Sent %0d put, %0d read, %0d clear, %0d scroll, %0d set-cursor beats and %0d %s",
               func_count[FN_PUT], func_count[FN_READ], func_count[FN_CLEAR],
               func_count[FN_SCROLL], func_count[FN_CURSOR],
               func_count[FN_UNUSED_LO] + func_count[FN_UNUSED_LO + 3'd1] +
               func_count[FN_UNUSED_HI], "unused-code beats");
      $display("Checked %0d response beats across %0d fill colors", checked_count,
               fill_settings + 1);
      if (error_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
